// File: src/lislt_pkg.sv
// Package for the LIS length tracker: sizes, payload structs, state encoding.
package lislt_pkg;

  localparam int unsigned MAX_LEN   = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_LEN);
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned OUT_LEN_W = 11;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    start_req;
  } in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] length;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_FIRST,
    ST_CHK_LAST,
    ST_SEARCH,
    ST_DONE
  } lislt_state_e;

endpackage

// File: src/lislt_tail_ram.sv
// Tail table memory: one write port, one registered read port.
module lislt_tail_ram
  import lislt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [ADDR_W-1:0]       waddr_i,
  input  logic signed [VAL_W-1:0] wdata_i,
  input  logic                    re_i,
  input  logic [ADDR_W-1:0]       raddr_i,
  output logic signed [VAL_W-1:0] rdata_o
);

  logic signed [VAL_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/lislt_ctrl.sv
// Sequencer: first/last tail checks, binary search and write-back on the tail RAM.
module lislt_ctrl
  import lislt_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_t                     in_data_i,
  input  logic                    res_ready_i,
  output res_t                    res_o,
  output logic                    ram_we_o,
  output logic [ADDR_W-1:0]       ram_waddr_o,
  output logic signed [VAL_W-1:0] ram_wdata_o,
  output logic                    ram_re_o,
  output logic [ADDR_W-1:0]       ram_raddr_o,
  input  logic signed [VAL_W-1:0] ram_rdata_i
);

  lislt_state_e state_q, state_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [ADDR_W-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic              ovf_q, ovf_d;

  logic              accept;
  logic [LEN_W-1:0]  len_eff;
  logic [ADDR_W-1:0] last_addr;
  logic              val_lt_rd, val_gt_rd, len_full;
  logic [ADDR_W-1:0] lo_n, hi_n, mid_n;
  logic              cont;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign len_eff    = in_data_i.start_req ? '0 : len_q;
  assign last_addr  = ADDR_W'(len_q - LEN_W'(1));
  assign val_lt_rd  = val_q < ram_rdata_i;
  assign val_gt_rd  = val_q > ram_rdata_i;
  assign len_full   = (len_q == LEN_W'(MAX_LEN));

  // one binary-search step on the tail just read at mid_q
  always_comb begin
    if (!val_gt_rd) begin
      lo_n = lo_q;
      hi_n = mid_q;
    end else begin
      lo_n = mid_q + ADDR_W'(1);
      hi_n = hi_q;
    end
    cont  = lo_n < hi_n;
    mid_n = lo_n + ((hi_n - lo_n) >> 1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (len_eff == '0) ? ST_DONE : ST_CHK_FIRST;
        end
      end
      ST_CHK_FIRST: state_d = val_lt_rd ? ST_DONE : ST_CHK_LAST;
      ST_CHK_LAST: begin
        if (val_gt_rd || last_addr == '0) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: state_d = cont ? ST_SEARCH : ST_DONE;
      ST_DONE:   state_d = res_ready_i ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // RAM control and datapath
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = val_q;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;
    val_d = val_q;
    len_d = len_q;
    lo_d  = lo_q;
    hi_d  = hi_q;
    mid_d = mid_q;
    ovf_d = ovf_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          val_d = in_data_i.value;
          ovf_d = 1'b0;
          len_d = len_eff;
          if (len_eff == '0) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = in_data_i.value;
            len_d       = LEN_W'(1);
          end else begin
            ram_re_o = 1'b1;
          end
        end
      end
      ST_CHK_FIRST: begin
        if (val_lt_rd) begin
          ram_we_o = 1'b1;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = last_addr;
        end
      end
      ST_CHK_LAST: begin
        if (val_gt_rd) begin
          if (len_full) begin
            ovf_d = 1'b1;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = ADDR_W'(len_q);
            len_d       = len_q + LEN_W'(1);
          end
        end else if (last_addr == '0) begin
          ram_we_o = 1'b1;
        end else begin
          lo_d        = '0;
          hi_d        = last_addr;
          mid_d       = last_addr >> 1;
          ram_re_o    = 1'b1;
          ram_raddr_o = last_addr >> 1;
        end
      end
      ST_SEARCH: begin
        lo_d = lo_n;
        hi_d = hi_n;
        if (cont) begin
          mid_d       = mid_n;
          ram_re_o    = 1'b1;
          ram_raddr_o = mid_n;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = lo_n;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign res_o.valid         = (state_q == ST_DONE);
  assign res_o.data.length   = OUT_LEN_W'(len_q);
  assign res_o.data.overflow = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    ovf_q <= ovf_d;
  end

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(MAX_LEN))
    else $error("tail length above table size");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.data.overflow |-> len_full)
    else $error("overflow reported with table not full");

  a_search_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> lo_q < hi_q && mid_q < hi_q)
    else $error("search window empty");

  a_write_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> state_q == ST_DONE)
    else $error("tail write not followed by result");

endmodule

// File: src/lis_length_tracker_core.sv
// Top level of the LIS length tracker: sequencer, tail RAM and output register.
// Steps from accept to result: an empty sequence writes the first tail at once;
// otherwise the first tail is read and checked (new first tail), then the last
// tail (append or overflow), then a binary search with one tail RAM read per step.
// One transaction at a time; the next is taken once the result enters the
// output register. Reset clears the length and control; the tail RAM is not.
module lis_length_tracker_core
  import lislt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  res_t                    res;
  logic                    res_ready;
  logic                    ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic signed [VAL_W-1:0] ram_wdata, ram_rdata;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_q, out_d;

  lislt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  lislt_tail_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_ready) begin
      out_valid_d = res.valid;
      if (res.valid) begin
        out_d = res.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
